>>> rtl/sfs_pkg.sv
// Package for the sorted table floor search block.
// Holds command codes, register indexes, FSM state and control/status structs.
// No dependencies.
package sfs_pkg;

    // Item kinds carried on s_tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam logic REG_BASE_OFFSET = 1'b0;
    localparam logic REG_ENTRY_COUNT = 1'b1;

    // Field widths fixed by the interface
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned COUNT_W = 13;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } sfs_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic wr_en;     // store the accepted write beat in the table
        logic start;     // latch query and open search range
        logic step;      // one probe: compare, narrow the range
        logic out_load;  // move result into the output register
    } sfs_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic cnt_zero;  // effective entry count is zero
        logic done;      // this probe hit or emptied the range
        logic out_free;  // output register can take a new result
    } sfs_stat_t;

endpackage

>>> rtl/sfs_ctrl.sv
// Controller FSM for the sorted table floor search block.
// Sequences accept, probe loop and result hand-off. Depends on sfs_pkg.
module sfs_ctrl
    import sfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_kind,
    output logic      in_ready,
    input  sfs_stat_t stat,
    output sfs_cmd_t  cmd
);

    sfs_state_t state_reg;
    sfs_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == CMD_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = stat.cnt_zero ? ST_FINISH : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sfs_datapath.sv
// Datapath for the sorted table floor search block: offset table memory,
// config registers, search range registers and output register. Depends on sfs_pkg.
module sfs_datapath
    import sfs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration writes
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    // accepted beat payload
    input  logic [INDEX_W-1:0]   entry_index,
    input  logic [ADDR_W-1:0]    entry_value,
    input  logic [ADDR_W-1:0]    query_addr,
    // control
    input  sfs_cmd_t             cmd,
    output sfs_stat_t            stat,
    // result channel
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 out_found,
    output logic [INDEX_W-1:0]   out_index
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // Table storage, undefined until written
    logic [ADDR_W-1:0]  offset_table_reg [TABLE_DEPTH];
    logic [ADDR_W-1:0]  rd_data_reg;

    // Config registers
    logic [ADDR_W-1:0]  base_offset_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    // Search state
    logic [ADDR_W-1:0]  query_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hi_reg;
    logic [AW-1:0]      mid_reg;
    logic               res_found_reg;
    logic [INDEX_W-1:0] res_index_reg;

    // Output register
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic [CW-1:0]      eff_count;
    logic [ADDR_W-1:0]  probe_val;
    logic               hit;
    logic               below;
    logic [CW-1:0]      mid_ext;
    logic [CW-1:0]      step_lo;
    logic [CW-1:0]      step_hi;
    logic               step_empty;
    logic [CW-1:0]      rng_lo;
    logic [CW-1:0]      rng_hi;
    logic [CW:0]        mid_sum;
    logic [AW-1:0]      rd_addr;
    logic               wr_ok;

    // Config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= '0;
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BASE_OFFSET: base_offset_reg <= cfg_wdata;
                REG_ENTRY_COUNT: entry_count_reg <= cfg_wdata[COUNT_W-1:0];
                default:         base_offset_reg <= base_offset_reg;
            endcase
        end
    end

    // Entries searched: count clamped to the table depth
    always_comb
    begin
        if (32'(entry_count_reg) > 32'(TABLE_DEPTH))
        begin
            eff_count = CW'(TABLE_DEPTH);
        end
        else
        begin
            eff_count = CW'(entry_count_reg);
        end
    end

    // Probe compare against rebased entry
    assign probe_val  = rd_data_reg + base_offset_reg;
    assign hit        = (query_reg == probe_val);
    assign below      = (query_reg < probe_val);
    assign mid_ext    = CW'(mid_reg);
    assign step_lo    = below ? lo_reg : (mid_ext + CW'(1));
    assign step_hi    = below ? mid_ext : hi_reg;
    assign step_empty = (step_lo >= step_hi);

    // Next probe address: midpoint of the range being opened or narrowed
    assign rng_lo  = cmd.start ? '0 : step_lo;
    assign rng_hi  = cmd.start ? eff_count : step_hi;
    assign mid_sum = ((CW + 1)'(rng_lo) + (CW + 1)'(rng_hi) - (CW + 1)'(1)) >> 1;
    assign rd_addr = AW'(mid_sum);

    assign wr_ok = (32'(entry_index) < 32'(TABLE_DEPTH));

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            offset_table_reg[AW'(entry_index)] <= entry_value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= offset_table_reg[rd_addr];
    end

    // Search range and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            query_reg     <= query_addr;
            lo_reg        <= '0;
            hi_reg        <= eff_count;
            mid_reg       <= rd_addr;
            res_found_reg <= 1'b0;
            res_index_reg <= '0;
        end
        else if (cmd.step)
        begin
            lo_reg  <= step_lo;
            hi_reg  <= step_hi;
            mid_reg <= rd_addr;
            if (hit)
            begin
                res_found_reg <= 1'b1;
                res_index_reg <= INDEX_W'(mid_reg);
            end
            else
            begin
                res_found_reg <= 1'b0;
                res_index_reg <= (step_hi == '0) ? '0 : INDEX_W'(step_hi - CW'(1));
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_index_reg <= res_index_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_index = out_index_reg;

    // Status to controller
    assign stat.cnt_zero = (eff_count == '0);
    assign stat.done     = hit || step_empty;
    assign stat.out_free = !out_valid_reg || out_ready;

`ifndef SYNTHESIS
    // Never overwrite a result still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // A probe only runs over a non-empty range
    a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (lo_reg < hi_reg))
        else $error("probe on empty range");

    // Probe index stays inside the range
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((mid_ext >= lo_reg) && (mid_ext < hi_reg)))
        else $error("probe index outside range");

    // A loaded result is presented next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

>>> rtl/sorted_table_floor_search.sv
// Floor lookup by binary search over a sorted table of 32-bit offsets.
// Write beat: stored in the table when accepted in idle. Lookup beat: accepted in
// idle, then one probe per step (up to floor(log2(n))+1, 13 at 4096 entries), then
// the result is loaded once the output register is free; no new beat is taken until then.
// Reset clears control, config registers and the output valid; the table is
// not cleared and holds unknown data until written.
module sorted_table_floor_search
    import sfs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // entry_index[11:0], entry_value[43:12], query_addr[75:44]
    input  logic        s_tuser,   // cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // match_index[11:0]
    output logic        m_tuser    // found
);

    sfs_cmd_t           cmd;
    sfs_stat_t          stat;
    logic [INDEX_W-1:0] out_index;

    sfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .entry_index (s_tdata[11:0]),
        .entry_value (s_tdata[43:12]),
        .query_addr  (s_tdata[75:44]),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_found   (m_tuser),
        .out_index   (out_index)
    );

    assign m_tdata = {4'b0000, out_index};

endmodule
